// ===== sv/hic_pkg.sv =====
// Shared types and constants for the Hilbert index-to-coordinate converter.
// No dependencies.
package hic_pkg;

   localparam int MAX_ORDER = 16;
   localparam int ORDER_W   = 5;
   localparam int INDEX_W   = 32;
   localparam int COORD_W   = 17;
   localparam int LEVEL_W   = 5;

   typedef enum logic [1:0] {
      QUAD_SWAP    = 2'd0,
      QUAD_UP      = 2'd1,
      QUAD_DIAG    = 2'd2,
      QUAD_REFLECT = 2'd3
   } hic_quad_type;

   // one beat as it moves along the cell chain
   typedef struct packed {
      logic [INDEX_W-1:0]   idx;    // remaining index bits, lowest level in [1:0]
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [MAX_ORDER-1:0] h;      // sub-square side at this cell
      logic [LEVEL_W-1:0]   left;   // levels still to apply
      logic                 err;
   } hic_beat_type;

endpackage

// ===== sv/hic_cell.sv =====
// One level of the Hilbert conversion chain, with its own beat register.
// Depends on hic_pkg.
module hic_cell
   import hic_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  hic_beat_type up_beat,
   output logic         dn_valid,
   input  logic         dn_ready,
   output hic_beat_type dn_beat
);

   logic         valid_ff;
   hic_beat_type beat_ff;
   hic_beat_type beat_in;
   hic_quad_type quad;
   logic [COORD_W-1:0] h_ext;
   logic [COORD_W-1:0] h_m1;

   assign quad  = hic_quad_type'(up_beat.idx[1:0]);
   assign h_ext = {{(COORD_W-MAX_ORDER){1'b0}}, up_beat.h};
   assign h_m1  = h_ext - COORD_W'(1);

   always_comb begin
      beat_in      = up_beat;
      beat_in.idx  = up_beat.idx >> 2;
      beat_in.h    = up_beat.h << 1;
      if (up_beat.left != '0) begin
         beat_in.left = up_beat.left - LEVEL_W'(1);
      end
      if (up_beat.left != '0 && !up_beat.err) begin
         unique case (quad)
            QUAD_SWAP: begin
               beat_in.x = up_beat.y;
               beat_in.y = up_beat.x;
            end
            QUAD_UP: begin
               beat_in.y = up_beat.y + h_ext;
            end
            QUAD_DIAG: begin
               beat_in.x = up_beat.x + h_ext;
               beat_in.y = up_beat.y + h_ext;
            end
            QUAD_REFLECT: begin
               beat_in.x = (h_m1 - up_beat.y) + h_ext;
               beat_in.y = h_m1 - up_beat.x;
            end
            default: begin
               beat_in.x = up_beat.x;
            end
         endcase
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         beat_ff <= beat_in;
      end
   end

endmodule

// ===== sv/hilbert_index_to_coordinate_top.sv =====
// Top level of the Hilbert index-to-coordinate converter: range check and cell chain.
// Depends on hic_pkg and hic_cell.
//
// Converts a Hilbert curve index into an (x, y) cell for the order held in the
// curve_order register (1 to 16, reset 1; larger values act as 16, zero gives
// x = y = 1 with the error flag). A beat passes through a chain of sixteen
// cells, one curve level per cell, each with its own register. One beat is
// taken every cycle while the chain is not stalled; since every cell has its
// own register, a stalled result does not stop requests until the chain is full. An
// index at or beyond four to the order returns x = y = side with the flag set.
// Write curve_order only while no beats are in flight.
module hilbert_index_to_coordinate_top
   import hic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] curve_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [16:0] x_coord, [33:17] y_coord, [39:34] zero
   output logic        rsp_tuser,   // [0] range_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_wdata    // curve_order
);

   logic [ORDER_W-1:0] order_ff;
   logic [ORDER_W-1:0] order_eff;
   logic               in_range;
   hic_beat_type       entry;

   logic         valid_c [0:MAX_ORDER];
   logic         ready_c [0:MAX_ORDER];
   hic_beat_type beat_c  [0:MAX_ORDER];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_W'(1);
      end else if (csr_valid) begin
         order_ff <= csr_wdata;
      end
   end

   assign order_eff = (order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_ff;

   // an index bound exists only while 4^n fits below the index width
   always_comb begin
      in_range = 1'b1;
      if (order_eff < ORDER_W'(INDEX_W / 2)) begin
         in_range = (req_tdata >> {order_eff, 1'b0}) == '0;
      end
   end

   always_comb begin
      entry      = '0;
      entry.idx  = req_tdata;
      entry.h    = MAX_ORDER'(1);
      entry.left = LEVEL_W'(order_eff);
      if (order_eff == '0) begin
         entry.err = 1'b1;
         entry.x   = COORD_W'(1);
         entry.y   = COORD_W'(1);
      end else if (!in_range) begin
         entry.err = 1'b1;
         entry.x   = COORD_W'(1) << order_eff;
         entry.y   = COORD_W'(1) << order_eff;
      end
   end

   assign valid_c[0] = req_tvalid;
   assign beat_c[0]  = entry;
   assign req_tready = ready_c[0];

   for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
      hic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_c[i]),
         .up_ready (ready_c[i]),
         .up_beat  (beat_c[i]),
         .dn_valid (valid_c[i+1]),
         .dn_ready (ready_c[i+1]),
         .dn_beat  (beat_c[i+1])
      );
   end

   assign ready_c[MAX_ORDER] = rsp_tready;
   assign rsp_tvalid         = valid_c[MAX_ORDER];
   assign rsp_tdata          = {6'b0, beat_c[MAX_ORDER].y, beat_c[MAX_ORDER].x};
   assign rsp_tuser          = beat_c[MAX_ORDER].err;

`ifndef ASSERT_OFF
   a_reset_clears_out : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_err_square : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[16:0] == rsp_tdata[33:17])
      else $error("error beat with unequal coordinates");

   a_in_side : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         (rsp_tdata[16:0] >> order_eff) == '0 && (rsp_tdata[33:17] >> order_eff) == '0)
      else $error("coordinate outside the curve square");

   a_pad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == '0)
      else $error("padding bits set");
`endif

endmodule
